// ===== rtl/core/ray_triangle_intersect_assert.svh =====
// ----------------------------------------------------------------------------
// Ray/triangle intersection: assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define RTI_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RTI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray/triangle intersection: shared package
// Flag bundle, register map and fixed widths used across the pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int QUOT_BITS      = 32;
  localparam int DIST_FRAC_BITS = 16;
  localparam int THRESH_BITS    = 40;
  localparam int APB_ADDR_BITS  = 4;
  localparam int APB_DATA_BITS  = 64;

  localparam logic [APB_ADDR_BITS-1:0] ADDR_DET_THRESHOLD  = 4'h0;
  localparam logic [THRESH_BITS-1:0]   DET_THRESHOLD_RESET = 40'd2;

  typedef struct packed {
    logic hit;
    logic backside;
    logic coplanar;
    logic tneg;
    logic tovf;
  } flags_t;

  function automatic int edge_bits(input int coord_bits);
    return coord_bits + 1;
  endfunction

  function automatic int cross_bits(input int coord_bits);
    return 2 * edge_bits(coord_bits) + 1;
  endfunction

  function automatic int dot_bits(input int coord_bits);
    return edge_bits(coord_bits) + cross_bits(coord_bits) + 2;
  endfunction

endpackage

// ===== rtl/core/rti_geom.sv =====
// ----------------------------------------------------------------------------
// Ray/triangle intersection: geometry pipeline
// Six stages forming edges, cross products and the four dot products.
// ----------------------------------------------------------------------------
module rti_geom #(
  parameter int COORD_BITS = 20
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [59:0] ray_origin,
  input  logic [59:0] ray_direction,
  input  logic [59:0] vertex_zero,
  input  logic [59:0] vertex_one,
  input  logic [59:0] vertex_two,
  output logic out_valid,
  output logic signed [rti_pkg::dot_bits(COORD_BITS)-1:0] dots [4]
);

  localparam int C  = COORD_BITS;
  localparam int E  = rti_pkg::edge_bits(C);
  localparam int CW = rti_pkg::cross_bits(C);
  localparam int DW = rti_pkg::dot_bits(C);
  localparam int LW = (CW + 1) / 2;
  localparam int HW = CW - LW;

  logic signed [C-1:0] o [3], d [3], p0 [3], p1 [3], p2 [3];

  logic [5:0] valid;

  logic signed [E-1:0] s1_d [3], s1_e0 [3], s1_e1 [3], s1_tv [3];
  logic signed [E-1:0] s2_d [3], s2_e0 [3], s2_e1 [3], s2_tv [3];
  logic signed [2*E-1:0] s2_pa [3], s2_pb [3], s2_qa [3], s2_qb [3];
  logic signed [E-1:0] s3_d [3], s3_e0 [3], s3_e1 [3], s3_tv [3];
  logic signed [CW-1:0] s3_pv [3], s3_qv [3];
  logic signed [E-1:0] da [4][3];
  logic signed [CW-1:0] db [4][3];
  logic signed [E+LW:0] s4_lo [4][3];
  logic signed [E+HW-1:0] s4_hi [4][3];
  logic signed [DW-1:0] s5_term [4][3];
  logic signed [DW-1:0] s6_dot [4];

  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign o[k]  = ray_origin[k*C +: C];
    assign d[k]  = ray_direction[k*C +: C];
    assign p0[k] = vertex_zero[k*C +: C];
    assign p1[k] = vertex_one[k*C +: C];
    assign p2[k] = vertex_two[k*C +: C];
  end

  for (genvar k = 0; k < 3; k++) begin : g_vec
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;

    always_ff @(posedge clk) begin
      if (en) begin
        s1_d[k]  <= E'(d[k]);
        s1_e0[k] <= E'(p1[k]) - E'(p0[k]);
        s1_e1[k] <= E'(p2[k]) - E'(p0[k]);
        s1_tv[k] <= E'(o[k]) - E'(p0[k]);

        s2_d[k]  <= s1_d[k];
        s2_e0[k] <= s1_e0[k];
        s2_e1[k] <= s1_e1[k];
        s2_tv[k] <= s1_tv[k];
        s2_pa[k] <= s1_d[K1] * s1_e1[K2];
        s2_pb[k] <= s1_d[K2] * s1_e1[K1];
        s2_qa[k] <= s1_tv[K1] * s1_e0[K2];
        s2_qb[k] <= s1_tv[K2] * s1_e0[K1];

        s3_d[k]  <= s2_d[k];
        s3_e0[k] <= s2_e0[k];
        s3_e1[k] <= s2_e1[k];
        s3_tv[k] <= s2_tv[k];
        s3_pv[k] <= CW'(s2_pa[k]) - CW'(s2_pb[k]);
        s3_qv[k] <= CW'(s2_qa[k]) - CW'(s2_qb[k]);
      end
    end

    assign da[0][k] = s3_e0[k];
    assign db[0][k] = s3_pv[k];
    assign da[1][k] = s3_tv[k];
    assign db[1][k] = s3_pv[k];
    assign da[2][k] = s3_d[k];
    assign db[2][k] = s3_qv[k];
    assign da[3][k] = s3_e1[k];
    assign db[3][k] = s3_qv[k];
  end

  for (genvar j = 0; j < 4; j++) begin : g_dot
    for (genvar k = 0; k < 3; k++) begin : g_term
      always_ff @(posedge clk) begin
        if (en) begin
          s4_lo[j][k]   <= da[j][k] * $signed({1'b0, db[j][k][LW-1:0]});
          s4_hi[j][k]   <= da[j][k] * $signed(db[j][k][CW-1:LW]);
          s5_term[j][k] <= (DW'(s4_hi[j][k]) <<< LW) + DW'(s4_lo[j][k]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s6_dot[j] <= s5_term[j][0] + s5_term[j][1] + s5_term[j][2];
      end
    end

    assign dots[j] = s6_dot[j];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[4:0], in_valid};
    end
  end

  assign out_valid = valid[5];

endmodule

// ===== rtl/core/rti_div.sv =====
// ----------------------------------------------------------------------------
// Ray/triangle intersection: pipelined divider
// Three restoring division lanes sharing one divisor, one quotient bit a stage.
// ----------------------------------------------------------------------------
module rti_div #(
  parameter int DW = 66,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  rti_pkg::flags_t in_flags,
  input  logic [DW-1:0] divisor,
  input  logic [DW-1:0] numer [3],
  output logic out_valid,
  output rti_pkg::flags_t out_flags,
  output logic [rti_pkg::QUOT_BITS-1:0] quot [3]
);

  localparam int QB = rti_pkg::QUOT_BITS;

  logic [DW-1:0] r_in [3];
  logic [QB-1:0] n_in [3];

  logic [DW-1:0] rr [QB][3];
  logic [QB-1:0] nn [QB][3];
  logic [QB-1:0] qq [QB][3];
  logic [DW-1:0] mag [QB];
  rti_pkg::flags_t flg [QB];
  logic [QB-1:0] valid;

  for (genvar l = 0; l < 3; l++) begin : g_lane_in
    localparam int S = (l == 2) ? rti_pkg::DIST_FRAC_BITS : WEIGHT_FRAC_BITS;
    assign r_in[l] = numer[l] >> (QB - S);
    assign n_in[l] = QB'(numer[l] << S);
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [DW-1:0] mag_prev;
    rti_pkg::flags_t flg_prev;
    logic valid_prev;

    if (s == 0) begin : g_first
      assign mag_prev   = divisor;
      assign flg_prev   = in_flags;
      assign valid_prev = in_valid;
    end else begin : g_next
      assign mag_prev   = mag[s-1];
      assign flg_prev   = flg[s-1];
      assign valid_prev = valid[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mag[s] <= mag_prev;
        flg[s] <= flg_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else if (en) begin
        valid[s] <= valid_prev;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DW-1:0] r_prev;
      logic [QB-1:0] n_prev, q_prev;
      logic [DW:0] trial, diff;
      logic take;

      if (s == 0) begin : g_first
        assign r_prev = r_in[l];
        assign n_prev = n_in[l];
        assign q_prev = '0;
      end else begin : g_next
        assign r_prev = rr[s-1][l];
        assign n_prev = nn[s-1][l];
        assign q_prev = qq[s-1][l];
      end

      assign trial = {r_prev, n_prev[QB-1]};
      assign diff  = trial - {1'b0, mag_prev};
      assign take  = trial >= {1'b0, mag_prev};

      always_ff @(posedge clk) begin
        if (en) begin
          rr[s][l] <= take ? diff[DW-1:0] : trial[DW-1:0];
          nn[s][l] <= {n_prev[QB-2:0], 1'b0};
          qq[s][l] <= {q_prev[QB-2:0], take};
        end
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quot[l] = qq[QB-1][l];
  end

  assign out_valid = valid[QB-1];
  assign out_flags = flg[QB-1];

endmodule

// ===== rtl/core/ray_triangle_intersect.sv =====
// ----------------------------------------------------------------------------
// Ray/triangle intersection (Moller-Trumbore), fixed point
// Streams ray/triangle pairs and returns hit flags, distance and weights.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Contents
//  request   req_valid / req_ready   ray origin, direction, three vertices
//  result    res_valid / res_ready   hit, backside, coplanar, distance, weights
//  config    APB write/read          det_threshold at byte address 0
//
//  One request enters per cycle unless a stalled result holds the pipeline;
//  each passes six geometry stages, two classification stages, 32 divider
//  stages and the output register. The divider, one quotient bit per stage,
//  sets the depth. Reset empties the pipeline and sets det_threshold to 2.
//  A stalled result holds the whole pipeline; nothing is dropped or repeated.
module ray_triangle_intersect #(
  parameter int COORD_BITS = 20,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [rti_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [rti_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [rti_pkg::APB_DATA_BITS-1:0] prdata,
  output logic pready,
  input  logic req_valid,
  output logic req_ready,
  input  logic [59:0] ray_origin,
  input  logic [59:0] ray_direction,
  input  logic [59:0] vertex_zero,
  input  logic [59:0] vertex_one,
  input  logic [59:0] vertex_two,
  output logic res_valid,
  input  logic res_ready,
  output logic hit,
  output logic backside,
  output logic coplanar,
  output logic signed [31:0] hit_distance,
  output logic [WEIGHT_FRAC_BITS:0] weight_zero,
  output logic [WEIGHT_FRAC_BITS:0] weight_one,
  output logic [WEIGHT_FRAC_BITS:0] weight_two
);

`include "ray_triangle_intersect_assert.svh"

  localparam int DW = rti_pkg::dot_bits(COORD_BITS);
  localparam int W  = WEIGHT_FRAC_BITS;
  localparam int QB = rti_pkg::QUOT_BITS;
  localparam int FB = rti_pkg::DIST_FRAC_BITS;

  logic [rti_pkg::THRESH_BITS-1:0] det_threshold;
  logic en;
  logic cfg_write;

  logic geom_valid;
  logic signed [DW-1:0] dots [4];

  logic s7_valid, s7_cop, s7_neg;
  logic [DW-1:0] s7_mag;
  logic signed [DW-1:0] s7_un, s7_vn, s7_tn;
  logic signed [DW-1:0] det_neg;
  logic [DW-1:0] det_mag;

  logic s8_valid;
  rti_pkg::flags_t s8_flags, s8_flags_next;
  logic [DW-1:0] s8_mag;
  logic [DW-1:0] s8_num [3];
  logic signed [DW:0] uv_sum;
  logic [DW-1:0] t_abs;

  logic div_valid;
  rti_pkg::flags_t div_flags;
  logic [QB-1:0] quot [3];

  logic [W:0] w1, w2, w0;
  logic [QB-1:0] dist_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == rti_pkg::ADDR_DET_THRESHOLD);
  assign prdata    = (paddr == rti_pkg::ADDR_DET_THRESHOLD) ?
                     rti_pkg::APB_DATA_BITS'(det_threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_threshold <= rti_pkg::DET_THRESHOLD_RESET;
    end else if (cfg_write) begin
      det_threshold <= pwdata[rti_pkg::THRESH_BITS-1:0];
    end
  end

  assign en        = !res_valid || res_ready;
  assign req_ready = en;

  rti_geom #(
    .COORD_BITS(COORD_BITS)
  ) u_geom (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (req_valid),
    .ray_origin   (ray_origin),
    .ray_direction(ray_direction),
    .vertex_zero  (vertex_zero),
    .vertex_one   (vertex_one),
    .vertex_two   (vertex_two),
    .out_valid    (geom_valid),
    .dots         (dots)
  );

  assign det_neg = dots[0][DW-1] ? -dots[0] : dots[0];
  assign det_mag = det_neg;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_mag <= det_mag;
      s7_cop <= (dots[0] == '0) || (det_mag < DW'(det_threshold));
      s7_neg <= dots[0][DW-1];
      s7_un  <= dots[0][DW-1] ? -dots[1] : dots[1];
      s7_vn  <= dots[0][DW-1] ? -dots[2] : dots[2];
      s7_tn  <= dots[0][DW-1] ? -dots[3] : dots[3];
    end
  end

  assign uv_sum = (DW+1)'(s7_un) + (DW+1)'(s7_vn);
  assign t_abs  = s7_tn[DW-1] ? DW'(-s7_tn) : DW'(s7_tn);

  always_comb begin
    s8_flags_next          = '0;
    s8_flags_next.coplanar = s7_cop;
    s8_flags_next.backside = s7_neg && !s7_cop;
    s8_flags_next.hit      = !s7_cop && !s7_un[DW-1] && !s7_vn[DW-1] &&
                             (uv_sum <= $signed({1'b0, s7_mag}));
    s8_flags_next.tneg     = s7_tn[DW-1];
    s8_flags_next.tovf     = (DW+FB)'(t_abs) >= {s7_mag, {FB{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_flags  <= s8_flags_next;
      s8_mag    <= s7_mag;
      s8_num[0] <= DW'(s7_un);
      s8_num[1] <= DW'(s7_vn);
      s8_num[2] <= t_abs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
    end else if (en) begin
      s7_valid <= geom_valid;
      s8_valid <= s7_valid;
    end
  end

  rti_div #(
    .DW(DW),
    .WEIGHT_FRAC_BITS(W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s8_valid),
    .in_flags (s8_flags),
    .divisor  (s8_mag),
    .numer    (s8_num),
    .out_valid(div_valid),
    .out_flags(div_flags),
    .quot     (quot)
  );

  assign w1 = quot[0][W:0];
  assign w2 = quot[1][W:0];
  assign w0 = (W+1)'(1 << W) - w1 - w2;

  always_comb begin
    if (div_flags.tneg) begin
      if (div_flags.tovf || (quot[2] > 32'h8000_0000)) begin
        dist_next = 32'h8000_0000;
      end else begin
        dist_next = 32'd0 - quot[2];
      end
    end else begin
      if (div_flags.tovf || (quot[2] > 32'h7FFF_FFFF)) begin
        dist_next = 32'h7FFF_FFFF;
      end else begin
        dist_next = quot[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit          <= div_flags.hit;
      backside     <= div_flags.backside;
      coplanar     <= div_flags.coplanar;
      hit_distance <= div_flags.hit ? $signed(dist_next) : '0;
      weight_zero  <= div_flags.hit ? w0 : '0;
      weight_one   <= div_flags.hit ? w1 : '0;
      weight_two   <= div_flags.hit ? w2 : '0;
    end
  end

  `RTI_ASSERT_SAME(a_coplanar_clean, res_valid && coplanar,
    !hit && !backside && (hit_distance == '0), "coplanar result carries hit data")

  `RTI_ASSERT_SAME(a_miss_zero, res_valid && !hit,
    (hit_distance == '0) && (weight_zero == '0) && (weight_one == '0) && (weight_two == '0),
    "miss result carries non-zero distance or weights")

  `RTI_ASSERT_SAME(a_weight_sum, res_valid && hit,
    (({2'b00, weight_zero} + {2'b00, weight_one} + {2'b00, weight_two}) == (W+3)'(1 << W)),
    "barycentric weights do not sum to one")

  `RTI_ASSERT_NEXT(a_cfg_write, psel && penable && pwrite && (paddr == rti_pkg::ADDR_DET_THRESHOLD),
    det_threshold == $past(pwdata[rti_pkg::THRESH_BITS-1:0]), "threshold write lost")

endmodule
